FILE: rtl/core/tcp_reset_probe_filter_unit_macros.svh
// Assertion macros for the filter RTL.
`ifndef TCP_RESET_PROBE_FILTER_UNIT_MACROS_SVH
`define TCP_RESET_PROBE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TRPF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/trpf_pkg.sv
// Types and constants of the TCP reset probe filter.
`timescale 1ns / 1ps

package trpf_pkg;

  localparam int POS_W        = 16;
  localparam int LEN_W        = POS_W + 1;
  localparam int HDR_BYTES_W  = 6;
  localparam int ADDR_W       = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int MAX_RANGES   = 4;
  localparam int NUM_RANGES   = 4;
  localparam int CFG_INDEX_W  = $clog2(2 * MAX_RANGES);
  localparam int RANGE_IDX_W  = CFG_INDEX_W - 1;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [HDR_BYTES_W-1:0] MIN_HDR_BYTES = 6'd20;
  localparam int TCP_RST_BIT = 2;

  // Fixed byte positions within the frame
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [POS_W-1:0] POS_IP_VIHL  = 16'd14;
  localparam logic [POS_W-1:0] POS_TLEN_HI  = 16'd16;
  localparam logic [POS_W-1:0] POS_TLEN_LO  = 16'd17;
  localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
  localparam logic [POS_W-1:0] POS_DEST_0   = 16'd30;
  localparam logic [POS_W-1:0] POS_DEST_1   = 16'd31;
  localparam logic [POS_W-1:0] POS_DEST_2   = 16'd32;
  localparam logic [POS_W-1:0] POS_DEST_3   = 16'd33;
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  // Byte offsets within the TCP header
  localparam logic [POS_W-1:0] TCP_SEQ_FIRST = 16'd4;
  localparam logic [POS_W-1:0] TCP_SEQ_LAST  = 16'd7;
  localparam logic [POS_W-1:0] TCP_DOFF      = 16'd12;
  localparam logic [POS_W-1:0] TCP_FLAGS     = 16'd13;
  localparam logic [POS_W-1:0] TCP_WIN_HI    = 16'd14;
  localparam logic [POS_W-1:0] TCP_WIN_LO    = 16'd15;

  localparam logic [ADDR_W-1:0] RANGE_LO_RST [MAX_RANGES] = '{
    32'd167772160, 32'd2886729728, 32'd3232235520, 32'd2130706432
  };
  localparam logic [ADDR_W-1:0] RANGE_HI_RST [MAX_RANGES] = '{
    32'd184549375, 32'd2887778303, 32'd3232301055, 32'd2147483647
  };

  typedef enum logic [2:0] {
    VERDICT_PUBLIC   = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_NOT_IPV4 = 3'd2,
    VERDICT_NOT_TCP  = 3'd3,
    VERDICT_MISMATCH = 3'd4,
    VERDICT_RESERVED = 3'd5
  } verdict_e;

  // Header fields of one finished frame
  typedef struct packed {
    logic [LEN_W-1:0]       frame_len;
    logic [15:0]            ether_type;
    logic [HDR_BYTES_W-1:0] ip_hdr_bytes;
    logic [15:0]            ip_length;
    logic [7:0]             ip_proto;
    logic [ADDR_W-1:0]      dest;
    logic [HDR_BYTES_W-1:0] tcp_hdr_bytes;
    logic [31:0]            tcp_seq;
    logic [7:0]             tcp_flags;
    logic [15:0]            tcp_window;
  } hdr_rec_t;

endpackage

FILE: rtl/core/trpf_front.sv
// Byte-serial header parser: counts position and captures header fields.
`timescale 1ns / 1ps

module trpf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           frame_byte_i,
  input  logic                 last_byte_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output trpf_pkg::hdr_rec_t   push_rec_o
);
  import trpf_pkg::*;

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [15:0]            etype_q, etype_d;
  logic [HDR_BYTES_W-1:0] ihl_q, ihl_d;
  logic [15:0]            tlen_q, tlen_d;
  logic [7:0]             proto_q, proto_d;
  logic [ADDR_W-1:0]      dest_q, dest_d;
  logic [HDR_BYTES_W-1:0] thl_q, thl_d;
  logic [31:0]            seq_q, seq_d;
  logic [7:0]             flags_q, flags_d;
  logic [15:0]            win_q, win_d;

  logic [POS_W-1:0] tcp_base;
  logic [POS_W-1:0] tcp_ofs;
  logic             in_tcp;
  logic             take;

  assign in_ready_o = !queue_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = take && last_byte_i;

  // Start of the TCP header, from the registered IHL
  assign tcp_base = POS_W'(ETH_HDR_LEN) + POS_W'(ihl_q);
  assign in_tcp   = (ihl_q >= MIN_HDR_BYTES) && (pos_q >= tcp_base);
  assign tcp_ofs  = pos_q - tcp_base;

  always_comb begin
    etype_d = etype_q;
    ihl_d   = ihl_q;
    tlen_d  = tlen_q;
    proto_d = proto_q;
    dest_d  = dest_q;
    thl_d   = thl_q;
    seq_d   = seq_q;
    flags_d = flags_q;
    win_d   = win_q;

    case (pos_q)
      POS_ETYPE_HI: etype_d = {frame_byte_i, etype_q[7:0]};
      POS_ETYPE_LO: etype_d = {etype_q[15:8], frame_byte_i};
      POS_IP_VIHL:  ihl_d   = {frame_byte_i[3:0], 2'b00};
      POS_TLEN_HI:  tlen_d  = {frame_byte_i, tlen_q[7:0]};
      POS_TLEN_LO:  tlen_d  = {tlen_q[15:8], frame_byte_i};
      POS_PROTO:    proto_d = frame_byte_i;
      POS_DEST_0, POS_DEST_1, POS_DEST_2, POS_DEST_3:
        dest_d = {dest_q[ADDR_W-9:0], frame_byte_i};
      default: ;
    endcase

    if (in_tcp) begin
      if (tcp_ofs >= TCP_SEQ_FIRST && tcp_ofs <= TCP_SEQ_LAST) begin
        seq_d = {seq_q[23:0], frame_byte_i};
      end else if (tcp_ofs == TCP_DOFF) begin
        thl_d = {frame_byte_i[7:4], 2'b00};
      end else if (tcp_ofs == TCP_FLAGS) begin
        flags_d = frame_byte_i;
      end else if (tcp_ofs == TCP_WIN_HI) begin
        win_d = {frame_byte_i, win_q[7:0]};
      end else if (tcp_ofs == TCP_WIN_LO) begin
        win_d = {win_q[15:8], frame_byte_i};
      end
    end

    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
  end

  always_comb begin
    push_rec_o.frame_len     = LEN_W'(pos_q) + LEN_W'(1);
    push_rec_o.ether_type    = etype_d;
    push_rec_o.ip_hdr_bytes  = ihl_d;
    push_rec_o.ip_length     = tlen_d;
    push_rec_o.ip_proto      = proto_d;
    push_rec_o.dest          = dest_d;
    push_rec_o.tcp_hdr_bytes = thl_d;
    push_rec_o.tcp_seq       = seq_d;
    push_rec_o.tcp_flags     = flags_d;
    push_rec_o.tcp_window    = win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      ihl_q   <= '0;
      tlen_q  <= '0;
      proto_q <= '0;
      dest_q  <= '0;
      thl_q   <= '0;
      seq_q   <= '0;
      flags_q <= '0;
      win_q   <= '0;
    end else if (take) begin
      if (last_byte_i) begin
        pos_q   <= '0;
        etype_q <= '0;
        ihl_q   <= '0;
        tlen_q  <= '0;
        proto_q <= '0;
        dest_q  <= '0;
        thl_q   <= '0;
        seq_q   <= '0;
        flags_q <= '0;
        win_q   <= '0;
      end else begin
        pos_q   <= pos_d;
        etype_q <= etype_d;
        ihl_q   <= ihl_d;
        tlen_q  <= tlen_d;
        proto_q <= proto_d;
        dest_q  <= dest_d;
        thl_q   <= thl_d;
        seq_q   <= seq_d;
        flags_q <= flags_d;
        win_q   <= win_d;
      end
    end
  end

endmodule

FILE: rtl/core/trpf_fifo.sv
// Two-entry queue of frame header records between parser and judge.
`timescale 1ns / 1ps

module trpf_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  trpf_pkg::hdr_rec_t push_rec_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output trpf_pkg::hdr_rec_t pop_rec_o
);
  import trpf_pkg::*;

  hdr_rec_t              entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign full_o    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_rec_o = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/trpf_judge.sv
// Verdict unit: range registers, header checks and the result register.
`timescale 1ns / 1ps

module trpf_judge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [trpf_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [trpf_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  queue_empty_i,
  input  trpf_pkg::hdr_rec_t                    rec_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [2:0]                            verdict_o,
  output logic [trpf_pkg::ADDR_W-1:0]           dest_address_o
);
  import trpf_pkg::*;

  logic [ADDR_W-1:0] range_lo_q [MAX_RANGES];
  logic [ADDR_W-1:0] range_hi_q [MAX_RANGES];
  logic [RANGE_IDX_W-1:0] cfg_range;

  logic              out_valid_q;
  verdict_e          verdict_q, verdict_d;
  logic [ADDR_W-1:0] dest_q;

  logic [7:0]  ip_end;
  logic [7:0]  tcp_end;
  logic [15:0] payload;
  logic        crit_ok;
  logic        reserved;

  assign cfg_range = cfg_index_i[CFG_INDEX_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo_q <= RANGE_LO_RST;
      range_hi_q <= RANGE_HI_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i[0]) begin
        range_hi_q[cfg_range] <= cfg_data_i[ADDR_W-1:0];
      end else begin
        range_lo_q[cfg_range] <= cfg_data_i[ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    reserved = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (rec_i.dest >= range_lo_q[i] && rec_i.dest <= range_hi_q[i]) begin
        reserved = 1'b1;
      end
    end
  end

  assign ip_end  = ETH_HDR_LEN + 8'(rec_i.ip_hdr_bytes);
  assign tcp_end = ip_end + 8'(rec_i.tcp_hdr_bytes);
  assign payload = rec_i.ip_length - 16'(rec_i.ip_hdr_bytes)
                 - 16'(rec_i.tcp_hdr_bytes);
  assign crit_ok = rec_i.tcp_flags[TCP_RST_BIT] && (rec_i.tcp_seq == 32'd1)
                && (rec_i.tcp_window == 16'd0) && (payload == 16'd0);

  always_comb begin
    if (rec_i.frame_len < LEN_W'(ETH_HDR_LEN)) begin
      verdict_d = VERDICT_SHORT;
    end else if (rec_i.ether_type != ETHERTYPE_IPV4) begin
      verdict_d = VERDICT_NOT_IPV4;
    end else if (rec_i.ip_hdr_bytes < MIN_HDR_BYTES
                 || rec_i.frame_len < LEN_W'(ip_end)) begin
      verdict_d = VERDICT_SHORT;
    end else if (rec_i.ip_proto != PROTO_TCP) begin
      verdict_d = VERDICT_NOT_TCP;
    end else if (rec_i.tcp_hdr_bytes < MIN_HDR_BYTES
                 || rec_i.frame_len < LEN_W'(tcp_end)) begin
      verdict_d = VERDICT_SHORT;
    end else if (!crit_ok) begin
      verdict_d = VERDICT_MISMATCH;
    end else if (reserved) begin
      verdict_d = VERDICT_RESERVED;
    end else begin
      verdict_d = VERDICT_PUBLIC;
    end
  end

  assign pop_o = !queue_empty_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      dest_q    <= rec_i.dest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_q;
  assign dest_address_o = dest_q;

endmodule

FILE: rtl/core/tcp_reset_probe_filter_unit.sv
// Top level of the TCP reset probe filter.
`timescale 1ns / 1ps
`include "tcp_reset_probe_filter_unit_macros.svh"

// Takes an Ethernet frame one byte per transfer (last_byte_i marks the end)
// and gives one result per frame: a verdict and the captured IPv4 destination.
// Verdict codes: 0 matching RST probe to a public address, 1 too short,
// 2 not IPv4, 3 not TCP, 4 criteria mismatch, 5 matching probe to a reserved
// destination. A probe matches when RST is set, sequence is 1, window is 0 and
// the payload (total length minus both header lengths, 16-bit wrap) is 0.
// Rate: one byte per clock while the queue has room, frames back to back. The
// parser front end captures fields at fixed and IHL-relative positions; on the
// last byte it writes a header record into a two-entry queue. The judge back
// end takes one record per clock unless its result waits on a stalled output,
// runs the checks and the range compares and registers the result; a frame's
// record passes the queue, then the result register, before out_valid_o rises.
// Input stalls only while both queue entries are held behind a stalled output.
// Reserved ranges are written through cfg_*: index 2n is the start of range n,
// 2n+1 its end, both inclusive; reset loads 10/8, 172.16/12, 192.168/16 and
// 127/8. Write them only while the block is idle.

module tcp_reset_probe_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        frame_byte_i,
  input  logic                              last_byte_i,
  // verdict output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        verdict_o,
  output logic [trpf_pkg::ADDR_W-1:0]       dest_address_o,
  // range configuration
  input  logic                              cfg_we_i,
  input  logic [trpf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [trpf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import trpf_pkg::*;

  hdr_rec_t push_rec;
  hdr_rec_t head_rec;
  logic     hdr_push;
  logic     hdr_pop;
  logic     fifo_full;
  logic     fifo_empty;

  // Front end: position counter and field capture
  trpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .queue_full_i (fifo_full),
    .push_o       (hdr_push),
    .push_rec_o   (push_rec)
  );

  // Decouples parsing from judging and output backpressure
  trpf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (hdr_push),
    .push_rec_i (push_rec),
    .full_o     (fifo_full),
    .pop_i      (hdr_pop),
    .empty_o    (fifo_empty),
    .pop_rec_o  (head_rec)
  );

  // Back end: checks, range lookup, result register
  trpf_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .queue_empty_i  (fifo_empty),
    .rec_i          (head_rec),
    .pop_o          (hdr_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .dest_address_o (dest_address_o)
  );

  // A new result only ever comes from a record taken off the queue
  `TRPF_ASSERT(a_result_from_pop, $rose(out_valid_o), $past(hdr_pop), "result without a queue pop")

  // With nothing ahead, a frame's result is up after the queue and result register
  `TRPF_ASSERT_NEXT(a_result_latency, in_valid_i && in_ready_o && last_byte_i && fifo_empty && !out_valid_o, ##1 out_valid_o, "result latency exceeded")

  // Queue never reports a record while also empty-flagged and full-flagged
  `TRPF_ASSERT(a_queue_flags, fifo_full, !fifo_empty, "queue full and empty at once")

endmodule

FILE: tb/sv/tcp_reset_probe_filter_unit_tb.sv
// Self-checking testbench for the TCP reset probe filter: frames in, verdicts checked.
`timescale 1ns / 1ps

module tcp_reset_probe_filter_unit_tb;
  import trpf_pkg::*;

  // Frame byte offsets and limits used by the frame builder and predictor
  localparam int ETH_BYTES      = ETH_HDR_LEN;
  localparam logic [7:0] FLAG_RST = 8'd1 << TCP_RST_BIT;
  localparam int MAX_GAP        = 40;    // cap on one sender idle stretch
  localparam int SETTLE_CYCLES  = 8;     // settle time after owed verdicts drain
  localparam int TAIL_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int MAX_SHOWN      = 10;

  // Register map: index 2n is the start of range n, 2n+1 its end
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_START_0, REG_RANGE_END_0,
    REG_RANGE_START_1, REG_RANGE_END_1,
    REG_RANGE_START_2, REG_RANGE_END_2,
    REG_RANGE_START_3, REG_RANGE_END_3
  } range_reg_e;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [ADDR_W-1:0] dest;
  } verdict_rec_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             frame_byte_i = 8'd0;
  logic                   last_byte_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [2:0]             verdict_o;
  logic [ADDR_W-1:0]      dest_address_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  tcp_reset_probe_filter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_byte_i   (frame_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .dest_address_o (dest_address_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser's captures and the ranges
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]       pos_cnt;
  logic [15:0]            etype_cap;
  logic [HDR_BYTES_W-1:0] ihl_bytes;
  logic [15:0]            ip_len_cap;
  logic [7:0]             proto_cap;
  logic [ADDR_W-1:0]      dest_cap;
  logic [HDR_BYTES_W-1:0] doff_bytes;
  logic [31:0]            seq_cap;
  logic [7:0]             flags_cap;
  logic [15:0]            win_cap;
  logic [ADDR_W-1:0]      rsv_lo [MAX_RANGES];
  logic [ADDR_W-1:0]      rsv_hi [MAX_RANGES];

  verdict_rec_t pending_verdicts[$];   // verdicts owed by the block, oldest first
  logic [7:0]   frame_buf[$];          // header bytes of the frame being sent

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;              // chance per cycle that the sender holds off
  int recv_stall_pct = 0;              // chance per cycle that ready is low

  task automatic clear_frame_state();
    pos_cnt    = '0;
    etype_cap  = '0;
    ihl_bytes  = '0;
    ip_len_cap = '0;
    proto_cap  = '0;
    dest_cap   = '0;
    doff_bytes = '0;
    seq_cap    = '0;
    flags_cap  = '0;
    win_cap    = '0;
  endtask

  // Checks in priority order at the last byte; len is the saturated frame length
  function automatic verdict_e judge_frame(input int len);
    logic [15:0] payload;
    int i;
    if (len < ETH_BYTES) return VERDICT_SHORT;
    if (etype_cap != ETHERTYPE_IPV4) return VERDICT_NOT_IPV4;
    if (ihl_bytes < MIN_HDR_BYTES || len < ETH_BYTES + ihl_bytes) return VERDICT_SHORT;
    if (proto_cap != PROTO_TCP) return VERDICT_NOT_TCP;
    if (doff_bytes < MIN_HDR_BYTES || len < ETH_BYTES + ihl_bytes + doff_bytes)
      return VERDICT_SHORT;
    // payload length wraps at 16 bits
    payload = ip_len_cap - {10'd0, ihl_bytes} - {10'd0, doff_bytes};
    if (!(flags_cap[TCP_RST_BIT] && seq_cap == 32'd1 && win_cap == 16'd0 &&
          payload == 16'd0))
      return VERDICT_MISMATCH;
    // an inverted range (start above end) matches nothing by construction
    for (i = 0; i < NUM_RANGES; i++)
      if (dest_cap >= rsv_lo[i] && dest_cap <= rsv_hi[i]) return VERDICT_RESERVED;
    return VERDICT_PUBLIC;
  endfunction

  // Advance the predictor by one accepted byte
  task automatic track_byte(input logic [7:0] b, input logic last);
    int pos;
    int t;
    verdict_rec_t rec;
    pos = pos_cnt;
    case (pos_cnt)
      POS_ETYPE_HI: etype_cap[15:8] = b;
      POS_ETYPE_LO: etype_cap[7:0] = b;
      POS_IP_VIHL:  ihl_bytes = {b[3:0], 2'b00};
      POS_TLEN_HI:  ip_len_cap[15:8] = b;
      POS_TLEN_LO:  ip_len_cap[7:0] = b;
      POS_PROTO:    proto_cap = b;
      POS_DEST_0, POS_DEST_1, POS_DEST_2, POS_DEST_3: dest_cap = {dest_cap[23:0], b};
      default: ;
    endcase
    // TCP fields sit at an IHL-relative offset, only once IHL is sane
    if (ihl_bytes >= MIN_HDR_BYTES && pos >= ETH_BYTES + ihl_bytes) begin
      t = pos - ETH_BYTES - ihl_bytes;
      if (t >= TCP_SEQ_FIRST && t <= TCP_SEQ_LAST) seq_cap = {seq_cap[23:0], b};
      else if (t == TCP_DOFF) doff_bytes = {b[7:4], 2'b00};
      else if (t == TCP_FLAGS) flags_cap = b;
      else if (t == TCP_WIN_HI) win_cap[15:8] = b;
      else if (t == TCP_WIN_LO) win_cap[7:0] = b;
    end
    if (pos_cnt != POS_MAX) pos_cnt = pos_cnt + 1'b1;  // saturates, never wraps
    if (last) begin
      rec.verdict = judge_frame(pos + 1);
      rec.dest    = dest_cap;
      pending_verdicts.push_back(rec);
      clear_frame_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, compare each verdict transfer with the oldest
  // expectation. Both valid and ready are sampled as they stood before the edge.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : verdict_check
    verdict_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("verdict with none pending", 32'd0, {29'd0, verdict_o});
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_o !== want.verdict)
          flag_mismatch("verdict", {29'd0, want.verdict}, {29'd0, verdict_o});
        if (dest_address_o !== want.dest)
          flag_mismatch("dest_address", want.dest, dest_address_o);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: too long without any transfer means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One byte transfer. Valid stays high across back-to-back bytes; this task only
  // drops it when a gap is chosen, so it never falls and rises in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    track_byte(b, last);
  endtask

  // Send len bytes: the built header first, random filler after it
  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_byte((i < frame_buf.size()) ? frame_buf[i] : 8'($urandom_range(0, 255)),
                i == len - 1);
  endtask

  // Lay out Ethernet + IPv4 + TCP headers; unused bytes are random. A header
  // length field below five still gets a 20-byte body so the field is present.
  task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [15:0] tot_len, input logic [7:0] proto,
                             input logic [31:0] dst, input logic [3:0] doff,
                             input logic [31:0] seq, input logic [7:0] flags,
                             input logic [15:0] win);
    int base;
    int hdr_end;
    base    = ETH_BYTES + ((ihl >= 5) ? 4 * ihl : 20);
    hdr_end = base + ((ihl >= 5) ? ((doff >= 5) ? 4 * doff : 20) : 0);
    frame_buf.delete();
    repeat (hdr_end) frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf[POS_ETYPE_HI] = etype[15:8];
    frame_buf[POS_ETYPE_LO] = etype[7:0];
    frame_buf[POS_IP_VIHL]  = {4'h4, ihl};
    frame_buf[POS_TLEN_HI]  = tot_len[15:8];
    frame_buf[POS_TLEN_LO]  = tot_len[7:0];
    frame_buf[POS_PROTO]    = proto;
    frame_buf[POS_DEST_0]   = dst[31:24];
    frame_buf[POS_DEST_1]   = dst[23:16];
    frame_buf[POS_DEST_2]   = dst[15:8];
    frame_buf[POS_DEST_3]   = dst[7:0];
    if (ihl >= 5) begin
      base = ETH_BYTES + 4 * ihl;
      frame_buf[base + TCP_SEQ_FIRST]     = seq[31:24];
      frame_buf[base + TCP_SEQ_FIRST + 1] = seq[23:16];
      frame_buf[base + TCP_SEQ_FIRST + 2] = seq[15:8];
      frame_buf[base + TCP_SEQ_LAST]      = seq[7:0];
      frame_buf[base + TCP_DOFF]          = {doff, 4'($urandom_range(0, 15))};
      frame_buf[base + TCP_FLAGS]         = flags;
      frame_buf[base + TCP_WIN_HI]        = win[15:8];
      frame_buf[base + TCP_WIN_LO]        = win[7:0];
    end
  endtask

  // A minimal matching probe: 20-byte headers, RST only, seq 1, window 0
  task automatic build_probe(input logic [31:0] dst);
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, dst, 4'd5, 32'd1, FLAG_RST,
                16'd0);
  endtask

  // Drop valid, let all owed verdicts drain, then give the pipeline time to empty
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; write enable is left high for the next write and lowered
  // by the caller once the sequence is done
  task automatic write_reg(input range_reg_e idx, input logic [31:0] data);
    logic [CFG_INDEX_W-1:0] raw;
    raw = idx;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (raw[0]) rsv_hi[raw[CFG_INDEX_W-1:1]] = data;
    else        rsv_lo[raw[CFG_INDEX_W-1:1]] = data;
  endtask

  task automatic program_range(input int n, input logic [31:0] lo, input logic [31:0] hi);
    write_reg(range_reg_e'(2 * n), lo);
    write_reg(range_reg_e'(2 * n + 1), hi);
  endtask

  // Destination near a range boundary, inside one, or anywhere
  function automatic logic [31:0] pick_dest();
    int r;
    r = $urandom_range(0, MAX_RANGES);
    if (r == MAX_RANGES) return $urandom;
    case ($urandom_range(0, 4))
      0: return rsv_lo[r];
      1: return rsv_hi[r];
      2: return rsv_lo[r] - 1;
      3: return rsv_hi[r] + 1;
      default: return (rsv_lo[r] <= rsv_hi[r]) ? $urandom_range(rsv_hi[r], rsv_lo[r])
                                                : rsv_lo[r];
    endcase
  endfunction

  // Mostly well-formed probes with one field disturbed at a time; some
  // truncated frames and some pure noise
  task automatic random_frame();
    logic [15:0] etype, tot_len, win;
    logic [3:0]  ihl, doff;
    logic [7:0]  proto, flags;
    logic [31:0] dst, seq;
    int kind, extra, len;
    kind  = $urandom_range(0, 15);
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    doff  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    tot_len = 16'(4 * ihl + 4 * doff);
    if ($urandom_range(0, 1)) tot_len = tot_len + 16'(extra);  // payload vs padding
    etype = ETHERTYPE_IPV4;
    proto = PROTO_TCP;
    seq   = 32'd1;
    win   = 16'd0;
    flags = 8'($urandom_range(0, 255));
    flags[TCP_RST_BIT] = 1'b1;
    dst   = pick_dest();
    case (kind)
      0: etype = ($urandom_range(0, 1)) ? 16'($urandom) : (ETHERTYPE_IPV4 ^ 16'h0100);
      1: proto = 8'($urandom_range(0, 255));
      2: ihl   = 4'($urandom_range(0, 15));
      3: doff  = 4'($urandom_range(0, 15));
      4: flags[TCP_RST_BIT] = 1'b0;
      5: seq   = ($urandom_range(0, 1)) ? $urandom : (32'd1 ^ (32'd1 << $urandom_range(0, 31)));
      6: win   = ($urandom_range(0, 1)) ? 16'($urandom) : (16'd1 << $urandom_range(0, 15));
      7: tot_len = 16'($urandom);
      default: ;
    endcase
    build_frame(etype, ihl, tot_len, proto, dst, doff, seq, flags, win);
    len = frame_buf.size() + extra;
    if (kind == 8) len = $urandom_range(1, frame_buf.size());
    if (kind == 9) begin
      frame_buf.delete();
      len = $urandom_range(1, 80);
    end
    send_frame(len);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frames ending before the Ethernet header, at its end, and inside the
  // destination field (partial destination shows up in the result)
  task automatic test_short_frames();
    build_probe(32'h0808_0808);
    send_frame(1);
    send_frame(ETH_BYTES - 1);
    send_frame(ETH_BYTES);
    send_frame(POS_DEST_3);
  endtask

  // Wrong EtherType, IHL below five, IPv4 header cut short, wrong protocol,
  // data offset below five, TCP header cut short
  task automatic test_header_checks();
    build_frame(16'h86DD, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1, FLAG_RST,
                16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd4, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd15, 16'd80, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(ETH_BYTES + 60 - 1);
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, 8'd17, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd36, PROTO_TCP, 32'h0808_0808, 4'd4, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_probe(32'h0808_0808);
    send_frame(frame_buf.size() - 1);
  endtask

  // Each match criterion broken alone, plus the widest headers with padding
  task automatic test_probe_criteria();
    build_probe(32'h0808_0808);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                ~FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd0,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5,
                32'h0100_0000, FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'h0001);
    send_frame(frame_buf.size());
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'h8000);
    send_frame(frame_buf.size());
    // one payload byte
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd41, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size() + 1);
    // total length below the header sum: payload wraps to a nonzero value
    build_frame(ETHERTYPE_IPV4, 4'd5, 16'd0, PROTO_TCP, 32'h0808_0808, 4'd5, 32'd1,
                FLAG_RST, 16'd0);
    send_frame(frame_buf.size());
    // 60-byte headers, all flags set, six bytes of link padding
    build_frame(ETHERTYPE_IPV4, 4'd15, 16'd120, PROTO_TCP, 32'hFFFF_FFFE, 4'd15, 32'd1,
                8'hFF, 16'd0);
    send_frame(frame_buf.size() + 6);
  endtask

  // Boundaries of the ranges loaded at reset
  task automatic test_default_ranges();
    build_probe(32'h0A00_0000); send_frame(frame_buf.size());
    build_probe(32'h09FF_FFFF); send_frame(frame_buf.size());
    build_probe(32'hAC1F_FFFF); send_frame(frame_buf.size());
    build_probe(32'hAC20_0000); send_frame(frame_buf.size());
    build_probe(32'hC0A8_0000); send_frame(frame_buf.size());
    build_probe(32'h7FFF_FFFF); send_frame(frame_buf.size());
    build_probe(32'h8000_0000); send_frame(frame_buf.size());
  endtask

  // Single-address ranges at both ends of the space, empty (inverted) ranges,
  // then one range covering everything
  task automatic test_range_extremes();
    quiesce();
    program_range(0, 32'h0000_0000, 32'h0000_0000);
    program_range(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    program_range(2, 32'h0000_0005, 32'h0000_0004);
    program_range(3, 32'hFFFF_FFFF, 32'h0000_0000);
    cfg_we_i <= 1'b0;
    build_probe(32'h0000_0000); send_frame(frame_buf.size());
    build_probe(32'hFFFF_FFFF); send_frame(frame_buf.size());
    build_probe(32'h0000_0004); send_frame(frame_buf.size());
    build_probe(32'h0000_0005); send_frame(frame_buf.size());
    quiesce();
    program_range(3, 32'h0000_0000, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b0;
    build_probe(32'h0000_0001); send_frame(frame_buf.size());
    build_probe(32'h5A5A_A5A5); send_frame(frame_buf.size());
  endtask

  // Random traffic in four flow-control phases, ranges reprogrammed between them
  task automatic test_random_traffic();
    int phase, n, start_bytes, frames;
    logic [31:0] lo, hi;
    for (phase = 0; phase < 4; phase++) begin
      quiesce();
      for (n = 0; n < MAX_RANGES; n++) begin
        lo = RANGE_LO_RST[n];
        hi = RANGE_HI_RST[n];
        if (phase != 0) begin
          case ($urandom_range(0, 4))
            0: ;
            1: begin lo = $urandom; hi = lo + $urandom_range(0, 32'h0010_0000); end
            2: begin lo = $urandom; hi = lo; end
            3: begin hi = $urandom; lo = hi + $urandom_range(1, 255); end
            default: begin
              lo = ($urandom_range(0, 1)) ? 32'h0000_0000 : $urandom;
              hi = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : lo + $urandom_range(0, 4095);
            end
          endcase
        end
        program_range(n, lo, hi);
      end
      cfg_we_i <= 1'b0;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      start_bytes = bytes_sent;
      frames = 0;
      while (bytes_sent - start_bytes < 80 || frames < 2) begin
        random_frame();
        frames++;
      end
    end
  endtask

  initial begin : run
    int i;
    for (i = 0; i < MAX_RANGES; i++) begin
      rsv_lo[i] = RANGE_LO_RST[i];
      rsv_hi[i] = RANGE_HI_RST[i];
    end
    clear_frame_state();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frames();
    test_header_checks();
    test_probe_criteria();
    test_default_ranges();
    test_range_extremes();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/trpf_pkg.sv
rtl/core/trpf_front.sv
rtl/core/trpf_fifo.sv
rtl/core/trpf_judge.sv
rtl/core/tcp_reset_probe_filter_unit.sv
tb/sv/tcp_reset_probe_filter_unit_tb.sv
